>>> rtl/cps_pkg.sv
// Shared types and constants for the palette select unit.
package cps_pkg;

	localparam int NUM_BINS = 256;
	localparam int BIN_W    = 8;
	localparam int COUNT_W  = 17;
	localparam int RANK_W   = 4;

	typedef logic [BIN_W-1:0]   bin_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [RANK_W-1:0]  rank_t;

	localparam count_t COUNT_CAP  = 17'd65536;
	localparam rank_t  PICKS      = 4'd15;
	localparam rank_t  RANK_FIRST = 4'd1;
	localparam bin_t   BIN_LAST   = 8'd255;

	typedef struct packed {
		logic  valid;
		logic  last_bin;
		logic  last_pick;
		rank_t rank;
	} rank_ctl_t;

endpackage

>>> rtl/cps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cps_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/cps_ranker.sv
// Running best-bin tracker for one ranking scan and the result word register.
module cps_ranker import cps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rank_ctl_t ctl_s1,
	input  bin_t      bin_s1,
	input  count_t    count_s1,
	output logic      strobe,
	output rank_t     rank,
	output bin_t      colour,
	output count_t    occurrences,
	output logic      last_rank
);

	logic   have_q;
	count_t best_cnt_q;
	bin_t   best_val_q;
	count_t prev_cnt_q;
	bin_t   prev_val_q;
	logic   eligible;
	logic   better;
	count_t nxt_cnt;
	bin_t   nxt_val;

	// bins ranked above the previous pick are already taken
	always_comb begin
		eligible = (ctl_s1.rank == RANK_FIRST) || (count_s1 < prev_cnt_q) ||
			((count_s1 == prev_cnt_q) && (bin_s1 > prev_val_q));
		better   = eligible && (!have_q || (count_s1 > best_cnt_q));
		nxt_cnt  = better ? count_s1 : best_cnt_q;
		nxt_val  = better ? bin_s1 : best_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= ctl_s1.valid && ctl_s1.last_bin;
			if (ctl_s1.valid) begin
				have_q <= ctl_s1.last_bin ? 1'b0 : (have_q | better);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			best_cnt_q <= nxt_cnt;
			best_val_q <= nxt_val;
			if (ctl_s1.last_bin) begin
				prev_cnt_q  <= nxt_cnt;
				prev_val_q  <= nxt_val;
				rank        <= ctl_s1.rank;
				colour      <= nxt_val;
				occurrences <= nxt_cnt;
				last_rank   <= ctl_s1.last_pick;
			end
		end
	end

endmodule

>>> rtl/top_colour_palette_select_unit.sv
// Top level of the palette select unit: histogram counting, scan control, ranking.
//
// Usage: a pixel word (pixel, last_pixel) is taken at a clock edge where start is
// high and busy is low. Pixels are counted into a 256-bin histogram, one per cycle
// while busy is low, held in a single-port-read RAM with a read-modify-write and
// forwarding between back-to-back pixels of the same value. Each bin saturates at
// 65536. When a word with last_pixel set is taken, busy rises and stays high through
// a drain state for the last count, then fifteen full scans of the RAM, one bin per
// cycle, each picking the highest untaken count (ties to the lowest colour). A result
// word shows on rank, colour, occurrences and last_rank for one cycle with strobe
// high, one per scan, and last_rank marks rank 15. The last scan writes each bin
// back to zero, so the next block can start as soon as busy falls.
// The receiver cannot stall; every strobe cycle is a delivered result.
// After reset busy stays high during a clearing pass over every bin of the RAM.
module top_colour_palette_select_unit import cps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  bin_t   pixel,
	input  logic   last_pixel,
	output logic   strobe,
	output rank_t  rank,
	output bin_t   colour,
	output count_t occurrences,
	output logic   last_rank
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_SCAN  = 2'd3;

	logic [1:0] state_q;
	bin_t       addr_q;
	rank_t      pick_q;

	logic       accept;
	logic       px_vld_s1;
	bin_t       addr_s1;
	rank_ctl_t  ctl_s1;
	rank_ctl_t  ctl_nxt;

	logic       fwd_vld_q;
	bin_t       fwd_addr_q;
	count_t     fwd_data_q;

	logic       ram_we;
	bin_t       ram_waddr;
	count_t     ram_wdata;
	bin_t       ram_raddr;
	count_t     ram_rdata;
	count_t     old_cnt;
	count_t     inc_cnt;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		old_cnt = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
		inc_cnt = (old_cnt < COUNT_CAP) ? old_cnt + count_t'(1) : old_cnt;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = inc_cnt;
		ram_raddr = (state_q == ST_SCAN) ? addr_q : pixel;
		priority if (px_vld_s1) begin
			ram_we = 1'b1;
		end else if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = '0;
		end else if ((state_q == ST_SCAN) && (pick_q == PICKS - RANK_FIRST)) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = '0;
		end
	end

	always_comb begin
		ctl_nxt.valid     = (state_q == ST_SCAN);
		ctl_nxt.last_bin  = (addr_q == BIN_LAST);
		ctl_nxt.last_pick = (pick_q == PICKS - RANK_FIRST);
		ctl_nxt.rank      = pick_q + RANK_FIRST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			pick_q    <= '0;
			px_vld_s1 <= 1'b0;
			fwd_vld_q <= 1'b0;
			ctl_s1    <= '0;
		end else begin
			px_vld_s1 <= accept;
			fwd_vld_q <= px_vld_s1;
			ctl_s1    <= ctl_nxt;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + bin_t'(1);
					if (addr_q == BIN_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && last_pixel) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_SCAN;
					addr_q  <= '0;
					pick_q  <= '0;
				end
				ST_SCAN: begin
					addr_q <= addr_q + bin_t'(1);
					if (addr_q == BIN_LAST) begin
						if (pick_q == PICKS - RANK_FIRST) begin
							state_q <= ST_IDLE;
							pick_q  <= '0;
						end else begin
							pick_q <= pick_q + RANK_FIRST;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= ram_raddr;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= inc_cnt;
	end

	cps_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (1'b1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cps_ranker u_ranker (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s1      (ctl_s1),
		.bin_s1      (addr_s1),
		.count_s1    (ram_rdata),
		.strobe      (strobe),
		.rank        (rank),
		.colour      (colour),
		.occurrences (occurrences),
		.last_rank   (last_rank)
	);

endmodule

>>> rtl/cps_checker.sv
// Port-level checks for the palette select unit and their binding.
module cps_checker import cps_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input logic   last_pixel,
	input logic   strobe,
	input rank_t  rank,
	input logic   last_rank
);

	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_rank == (rank == PICKS)))
		else $error("last_rank does not match final rank");

	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_pixel) |=> busy)
		else $error("busy did not rise after last pixel");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_rank) |-> busy)
		else $error("busy dropped before final rank");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_rank) |-> !$past(busy))
		else $error("busy still high before final rank");

	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results in adjacent cycles");

endmodule

bind top_colour_palette_select_unit cps_checker u_cps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.last_pixel (last_pixel),
	.strobe     (strobe),
	.rank       (rank),
	.last_rank  (last_rank)
);

>>> verif/tb_top.sv
// Testbench for the palette select unit: histogram ranking predictor, scoreboard and stimulus.
import cps_pkg::*;

typedef struct {
	rank_t  rank;
	bin_t   colour;
	count_t occurrences;
	logic   last_rank;
} palette_entry_t;

class palette_scoreboard;
	count_t         tally [NUM_BINS];
	bit             picked [NUM_BINS];
	palette_entry_t palette_due [$];
	int             failures;
	int             entries_checked;

	function new();
		clear_block();
		failures = 0;
		entries_checked = 0;
	endfunction

	function void clear_block();
		for (int v = 0; v < NUM_BINS; v++) begin
			tally[v] = '0;
			picked[v] = 1'b0;
		end
	endfunction

	function int pending();
		return palette_due.size();
	endfunction

	function void tally_pixel(bin_t px, logic lp);
		palette_entry_t e;
		int best;
		if (tally[px] < COUNT_CAP)
			tally[px]++;
		if (!lp)
			return;
		// rank by highest untaken count, ties to the lowest colour
		for (int k = 0; k < int'(PICKS); k++) begin
			best = -1;
			for (int v = 0; v < NUM_BINS; v++)
				if (!picked[v] && (best < 0 || tally[v] > tally[best]))
					best = v;
			picked[best] = 1'b1;
			e.rank = rank_t'(k + 1);
			e.colour = bin_t'(best);
			e.occurrences = tally[best];
			e.last_rank = (k == int'(PICKS) - 1);
			palette_due.push_back(e);
		end
		clear_block();
	endfunction

	function void match_palette_entry(rank_t r, bin_t c, count_t n, logic lr);
		palette_entry_t e;
		if (palette_due.size() == 0) begin
			$error("unexpected palette entry: rank %0d colour %0d occurrences %0d",
				r, c, n);
			failures++;
			return;
		end
		e = palette_due.pop_front();
		entries_checked++;
		if (r !== e.rank) begin
			$error("rank mismatch: expected %0d, got %0d", e.rank, r);
			failures++;
		end
		if (c !== e.colour) begin
			$error("colour mismatch: expected %0d, got %0d", e.colour, c);
			failures++;
		end
		if (n !== e.occurrences) begin
			$error("occurrences mismatch: expected %0d, got %0d", e.occurrences, n);
			failures++;
		end
		if (lr !== e.last_rank) begin
			$error("last_rank mismatch: expected %0d, got %0d", e.last_rank, lr);
			failures++;
		end
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 2000;

	logic   clk;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	bin_t   pixel = '0;
	logic   last_pixel = 1'b0;
	logic   strobe;
	rank_t  rank;
	bin_t   colour;
	count_t occurrences;
	logic   last_rank;

	palette_scoreboard sb = new();
	bit steady = 1'b0;
	int words_sent = 0;
	int blocks_sent = 0;
	int stall_cycles = 0;

	top_colour_palette_select_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.last_pixel(last_pixel),
		.strobe(strobe),
		.rank(rank),
		.colour(colour),
		.occurrences(occurrences),
		.last_rank(last_rank)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.tally_pixel(pixel, last_pixel);
			if (strobe)
				sb.match_palette_entry(rank, colour, occurrences, last_rank);
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(bin_t px, logic lp);
		if (!steady && $urandom_range(99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		last_pixel <= lp;
		do @(posedge clk); while (busy);
		words_sent++;
		if (lp)
			blocks_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic directed_blocks();
		bin_t ties [6] = '{8'd7, 8'd3, 8'd200, 8'd200, 8'd7, 8'd3};
		send_word(8'd0, 1'b1);
		wait_drained();
		send_word(8'd255, 1'b1);
		foreach (ties[i])
			send_word(ties[i], i == 5);
		// more colours than palette slots
		for (int i = 0; i < 16; i++)
			send_word(bin_t'(i * 17), i == 15);
	endtask

	task automatic random_blocks();
		bin_t shades [20];
		int words;
		int len;
		int nshades;
		int blk;
		bin_t px;
		words = 0;
		blk = 0;
		while (words < 136) begin
			len = ($urandom_range(99) < 15) ? $urandom_range(25, 60) : $urandom_range(1, 20);
			nshades = $urandom_range(1, 20);
			for (int i = 0; i < nshades; i++)
				shades[i] = bin_t'($urandom_range(255));
			steady = (blk == 2);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 75)
					px = shades[$urandom_range(nshades - 1)];
				else
					px = bin_t'($urandom_range(255));
				send_word(px, i == len - 1);
			end
			words += len;
			if (blk == 0 || $urandom_range(3) == 0)
				wait_drained();
			blk++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		directed_blocks();
		random_blocks();
		start <= 1'b0;
		wait_drained();
		repeat (300) @(posedge clk);
		$display("Drove %0d pixel words in %0d blocks, with ties and empty bins.",
			words_sent, blocks_sent);
		$display("Checked %0d palette entries against the predicted histogram ranking.",
			sb.entries_checked);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

>>> sim.f
rtl/cps_pkg.sv
rtl/cps_ram.sv
rtl/cps_ranker.sv
rtl/top_colour_palette_select_unit.sv
rtl/cps_checker.sv
verif/tb_top.sv
